// ===== rtl/tpda_pkg.sv =====
`default_nettype none
package tpda_pkg;

    // defaults for the top-level parameters
    localparam int DIST_FRAC_BITS_DEF = 10;
    localparam int DIST_WIDTH_DEF     = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_LON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS_KM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GIVEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LAT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LON   = 3'd5;

    // axis modes
    localparam logic [1:0] MODE_LAT  = 2'd0;
    localparam logic [1:0] MODE_LON  = 2'd1;
    localparam logic [1:0] MODE_DIST = 2'd2;

    // angles in 1/65536 degree
    localparam int DEG179 = 11730944;
    localparam int DEG180 = 11796480;
    localparam int DEG360 = 23592960;

    // fixed-point constants
    localparam int Q30ONE       = 1 << 30;
    localparam int RAD_PER_UNIT = 149922641;
    localparam int NM_PER_DEG   = 1006632960;
    localparam int KM_PER_DEG   = 1865541176;
    localparam int COS_STEPS    = 6;

    // shared serial multiplier
    localparam int MUL_OP_W   = 34;
    localparam int MUL_PROD_W = 2 * MUL_OP_W;
    localparam int MUL_CNT_W  = $clog2(MUL_OP_W + 1);

    // serial square root
    localparam int SQ_IN_W   = 64;
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W + 1);

    typedef struct packed {
        logic                 start;
        logic [MUL_OP_W-1:0]  mcand;
        logic [MUL_OP_W-1:0]  mplier;
        logic [MUL_CNT_W-1:0] count;
    } t_mul_req;

    // divisors of the nested cosine series
    function automatic logic [7:0] cos_div(input logic [2:0] idx);
        logic [7:0] k;
        unique case (idx)
            3'd0:    k = 8'd132;
            3'd1:    k = 8'd90;
            3'd2:    k = 8'd56;
            3'd3:    k = 8'd30;
            3'd4:    k = 8'd12;
            3'd5:    k = 8'd2;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tpda_mul.sv =====
`default_nettype none
module tpda_mul
    import tpda_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_mul_req              i_req,
    output logic                       o_busy,
    output logic [MUL_PROD_W-1:0]      o_prod
);

    logic                  r_busy;
    logic [MUL_CNT_W-1:0]  r_cnt;
    logic [MUL_PROD_W-1:0] r_mcand;
    logic [MUL_OP_W-1:0]   r_mplier;
    logic [MUL_PROD_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.count;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == MUL_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one multiplier bit per cycle, shift-add
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand  <= MUL_PROD_W'(i_req.mcand);
            r_mplier <= i_req.mplier;
            r_acc    <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[MUL_PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MUL_OP_W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule
`default_nettype wire

// ===== rtl/tpda_sqrt.sv =====
`default_nettype none
module tpda_sqrt
    import tpda_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SQ_IN_W-1:0]   i_value,
    output logic                      o_busy,
    output logic [SQ_ROOT_W-1:0]      o_root
);

    localparam int REM_W = SQ_ROOT_W + 2;

    logic                 r_busy;
    logic [SQ_CNT_W-1:0]  r_cnt;
    logic [SQ_IN_W-1:0]   r_val;
    logic [REM_W-1:0]     r_rem;
    logic [SQ_ROOT_W-1:0] r_root;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    // two radicand bits per cycle, one root bit
    always_comb begin
        rem_sh = {r_rem, r_val[SQ_IN_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQ_CNT_W'(SQ_ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == SQ_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[SQ_IN_W-3:0], 2'b00};
            r_rem  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            r_root <= {r_root[SQ_ROOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== rtl/track_position_distance_accumulator.sv =====
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        in         i_in_valid / o_in_stall   i_station_lat, i_station_lon
// out       out        o_out_valid / i_out_stall o_axis_value, o_sign_jump_warning,
//                                                o_distance_saturated
// cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Latitude, longitude, undefined-mode and first-station beats leave in the cycle after
// acceptance. A distance beat is paced by the shared shift-add multiplier (one
// multiplier bit per cycle, twelve products), the six bit-serial cosine
// divisions and the serial square root.
// One beat is in flight at a time; the next is taken once the engine is idle and
// the output register is free or being emptied. Reset is synchronous, active low.
// Output stall holds the result register and the input; the engine waits in its last state.
module track_position_distance_accumulator
    import tpda_pkg::*;
#(
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF,
    parameter int DIST_WIDTH     = DIST_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic signed [23:0]     i_station_lat,
    input  wire logic signed [25:0]     i_station_lon,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic signed [40:0]          o_axis_value,
    output logic                        o_sign_jump_warning,
    output logic                        o_distance_saturated,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int STEP_SHIFT = 44 - DIST_FRAC_BITS;
    localparam logic [DIST_WIDTH-1:0] MAXD = '1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MX   = 11'b000_0000_0010,
        S_MX2  = 11'b000_0000_0100,
        S_MP   = 11'b000_0000_1000,
        S_DIV  = 11'b000_0001_0000,
        S_MDX  = 11'b000_0010_0000,
        S_MSQX = 11'b000_0100_0000,
        S_MSQY = 11'b000_1000_0000,
        S_SQRT = 11'b001_0000_0000,
        S_MF   = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    // control and state
    t_state                r_state, n_state;
    logic                  r_ovld;
    logic [1:0]            r_mode;
    logic                  r_wrap;
    logic                  r_km;
    logic                  r_have_prev;
    logic                  r_warned;
    logic [DIST_WIDTH-1:0] r_total;
    logic signed [23:0]    r_prev_lat;
    logic signed [26:0]    r_prev_lon;
    logic [2:0]            r_kidx;

    // datapath
    logic [MUL_OP_W-1:0]   r_x2;
    logic [28:0]           r_dlon;
    logic [28:0]           r_dy;
    logic [63:0]           r_sum;
    logic [33:0]           r_dq;
    logic [7:0]            r_drem;
    logic [5:0]            r_dcnt;
    logic                  r_warn_now;
    logic [40:0]           r_axis;
    logic                  r_warn_o;
    logic                  r_sat_o;

    t_mul_req              mreq;
    logic                  mul_busy;
    logic [MUL_PROD_W-1:0] mul_prod;
    logic                  sq_start;
    logic [SQ_IN_W-1:0]    sq_val;
    logic                  sq_busy;
    logic [SQ_ROOT_W-1:0]  sq_root;

    tpda_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    tpda_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_val),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    logic               out_free;
    logic               in_acc;

    // position arithmetic at acceptance
    logic signed [26:0] lon_x;
    logic signed [26:0] lon_w;
    logic signed [29:0] lw30;
    logic signed [29:0] pl30;
    logic signed [29:0] pl2;
    logic signed [29:0] d1;
    logic signed [29:0] d2;
    logic [29:0]        ad1;
    logic [29:0]        ad2;
    logic               opp1;
    logic               opp2;
    logic               warn_hit;
    logic signed [24:0] lat25;
    logic signed [24:0] plat25;
    logic signed [24:0] lsum;
    logic signed [24:0] ldif;
    logic [24:0]        asum;
    logic [24:0]        afold;
    logic [24:0]        adif;

    always_comb begin
        lon_x  = {i_station_lon[25], i_station_lon};
        // force negative longitudes into 0..360 when asked
        lon_w  = (r_wrap && i_station_lon[25]) ? lon_x + 27'(DEG360) : lon_x;
        lw30   = {{3{lon_w[26]}}, lon_w};
        pl30   = {{3{r_prev_lon[26]}}, r_prev_lon};
        d1     = lw30 - pl30;
        ad1    = d1[29] ? 30'(-d1) : 30'(d1);
        opp1   = (lw30[29] && !pl30[29] && (pl30 != '0)) ||
                 (!lw30[29] && (lw30 != '0) && pl30[29]);
        // dateline: move the previous longitude to the current side
        if (opp1 && (ad1 > 30'(DEG180))) begin
            pl2 = lw30[29] ? pl30 - 30'(DEG360) : pl30 + 30'(DEG360);
        end else begin
            pl2 = pl30;
        end
        d2       = lw30 - pl2;
        ad2      = d2[29] ? 30'(-d2) : 30'(d2);
        opp2     = (lw30[29] && !pl2[29] && (pl2 != '0)) ||
                   (!lw30[29] && (lw30 != '0) && pl2[29]);
        warn_hit = opp2 && (ad2 > 30'(DEG179)) && !r_warned;

        lat25  = {i_station_lat[23], i_station_lat};
        plat25 = {r_prev_lat[23], r_prev_lat};
        lsum   = lat25 + plat25;
        asum   = lsum[24] ? 25'(-lsum) : 25'(lsum);
        // only |cos| matters: fold beyond 180 degrees of sum
        afold  = (asum > 25'(DEG180)) ? 25'(DEG360) - asum : asum;
        ldif   = lat25 - plat25;
        adif   = ldif[24] ? 25'(-ldif) : 25'(ldif);
    end

    // cosine series: serial division by a small constant
    logic [8:0]  d_rem_sh;
    logic [8:0]  d_k;
    logic        d_ge;
    logic [30:0] p_new;

    always_comb begin
        d_rem_sh = {r_drem, r_dq[33]};
        d_k      = 9'(cos_div(r_kidx));
        d_ge     = d_rem_sh >= d_k;
        p_new    = (r_dq >= 34'(Q30ONE)) ? '0 : 31'(34'(Q30ONE) - r_dq);
    end

    // distance step and saturating accumulate
    logic [63:0]           step64;
    logic [DIST_WIDTH-1:0] room;
    logic [DIST_WIDTH-1:0] total_next;

    always_comb begin
        step64     = 64'(mul_prod[62:0] >> STEP_SHIFT);
        room       = MAXD - r_total;
        total_next = (step64 >= 64'(room)) ? MAXD : r_total + DIST_WIDTH'(step64);
    end

    assign out_free   = !r_ovld || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    // sequencer: every transition before S_MF launches the next serial job
    logic        out_load;
    logic [40:0] out_axis;
    logic        out_warn;
    logic        out_sat;

    always_comb begin
        n_state  = r_state;
        mreq     = '0;
        sq_start = 1'b0;
        sq_val   = r_sum + mul_prod[63:0];
        out_load = 1'b0;
        out_axis = '0;
        out_warn = 1'b0;
        out_sat  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (r_mode)
                        MODE_LAT: begin
                            out_load = 1'b1;
                            out_axis = {{17{i_station_lat[23]}}, i_station_lat};
                        end
                        MODE_LON: begin
                            out_load = 1'b1;
                            out_axis = {{14{lon_w[26]}}, lon_w};
                        end
                        MODE_DIST: begin
                            if (r_have_prev) begin
                                mreq.start  = 1'b1;
                                mreq.mcand  = MUL_OP_W'(RAD_PER_UNIT);
                                mreq.mplier = MUL_OP_W'(afold);
                                mreq.count  = MUL_CNT_W'(24);
                                n_state     = S_MX;
                            end else begin
                                out_load = 1'b1;
                                out_axis = 41'(r_total);
                                out_sat  = r_total == MAXD;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            out_axis = '1;
                        end
                    endcase
                end
            end
            S_MX: begin
                if (!mul_busy) begin
                    mreq.start  = 1'b1;
                    mreq.mcand  = MUL_OP_W'(mul_prod[51:20]);
                    mreq.mplier = MUL_OP_W'(mul_prod[51:20]);
                    mreq.count  = MUL_CNT_W'(32);
                    n_state     = S_MX2;
                end
            end
            S_MX2: begin
                if (!mul_busy) begin
                    mreq.start  = 1'b1;
                    mreq.mcand  = mul_prod[63:30];
                    mreq.mplier = MUL_OP_W'(Q30ONE);
                    mreq.count  = MUL_CNT_W'(31);
                    n_state     = S_MP;
                end
            end
            S_MP: begin
                if (!mul_busy) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_dcnt == '0) begin
                    mreq.start = 1'b1;
                    if (r_kidx == 3'(COS_STEPS - 1)) begin
                        mreq.mcand  = MUL_OP_W'(p_new);
                        mreq.mplier = MUL_OP_W'(r_dlon);
                        mreq.count  = MUL_CNT_W'(29);
                        n_state     = S_MDX;
                    end else begin
                        mreq.mcand  = r_x2;
                        mreq.mplier = MUL_OP_W'(p_new);
                        mreq.count  = MUL_CNT_W'(31);
                        n_state     = S_MP;
                    end
                end
            end
            S_MDX: begin
                if (!mul_busy) begin
                    mreq.start  = 1'b1;
                    mreq.mcand  = MUL_OP_W'(mul_prod[58:26]);
                    mreq.mplier = MUL_OP_W'(mul_prod[58:26]);
                    mreq.count  = MUL_CNT_W'(33);
                    n_state     = S_MSQX;
                end
            end
            S_MSQX: begin
                if (!mul_busy) begin
                    mreq.start  = 1'b1;
                    mreq.mcand  = MUL_OP_W'(r_dy);
                    mreq.mplier = MUL_OP_W'(r_dy);
                    mreq.count  = MUL_CNT_W'(29);
                    n_state     = S_MSQY;
                end
            end
            S_MSQY: begin
                if (!mul_busy) begin
                    sq_start = 1'b1;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                if (!sq_busy) begin
                    mreq.start  = 1'b1;
                    mreq.mcand  = r_km ? MUL_OP_W'(KM_PER_DEG) : MUL_OP_W'(NM_PER_DEG);
                    mreq.mplier = MUL_OP_W'(sq_root);
                    mreq.count  = MUL_CNT_W'(32);
                    n_state     = S_MF;
                end
            end
            S_MF: begin
                if (!mul_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_axis = 41'(r_total);
                    out_warn = r_warn_now;
                    out_sat  = r_total == MAXD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovld      <= 1'b0;
            r_mode      <= MODE_DIST;
            r_wrap      <= 1'b0;
            r_km        <= 1'b0;
            r_have_prev <= 1'b0;
            r_warned    <= 1'b0;
            r_total     <= '0;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_kidx      <= '0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_AXIS_MODE:   r_mode      <= i_cfg_data[1:0];
                    CFG_WRAP_LON:    r_wrap      <= i_cfg_data[0];
                    CFG_UNITS_KM:    r_km        <= i_cfg_data[0];
                    CFG_START_GIVEN: r_have_prev <= i_cfg_data[0];
                    CFG_START_LAT:   r_prev_lat  <= i_cfg_data[23:0];
                    CFG_START_LON:   r_prev_lon  <= {i_cfg_data[25], i_cfg_data};
                    default: ;
                endcase
            end

            // in distance mode the station becomes the previous one as soon as it is taken
            if (in_acc && (r_mode == MODE_DIST)) begin
                r_prev_lat  <= i_station_lat;
                r_prev_lon  <= lon_w;
                r_have_prev <= 1'b1;
                if (r_have_prev && warn_hit) begin
                    r_warned <= 1'b1;
                end
            end

            if (in_acc) begin
                r_kidx <= '0;
            end else if ((r_state == S_DIV) && (r_dcnt == '0)) begin
                r_kidx <= r_kidx + 1'b1;
            end

            if ((r_state == S_MF) && !mul_busy) begin
                r_total <= total_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dlon     <= ad2[28:0];
            r_dy       <= {adif[24:0], 4'b0000};
            r_warn_now <= r_have_prev && warn_hit;
        end
        if ((r_state == S_MX2) && !mul_busy) begin
            r_x2 <= mul_prod[63:30];
        end
        if ((r_state == S_MP) && !mul_busy) begin
            r_dq   <= mul_prod[63:30];
            r_drem <= '0;
            r_dcnt <= 6'd34;
        end else if ((r_state == S_DIV) && (r_dcnt != '0)) begin
            r_dq   <= {r_dq[32:0], d_ge};
            r_drem <= d_ge ? 8'(d_rem_sh - d_k) : d_rem_sh[7:0];
            r_dcnt <= r_dcnt - 1'b1;
        end
        if ((r_state == S_MSQX) && !mul_busy) begin
            r_sum <= mul_prod[63:0];
        end
        if (out_load) begin
            r_axis   <= out_axis;
            r_warn_o <= out_warn;
            r_sat_o  <= out_sat;
        end
    end

    assign o_out_valid          = r_ovld;
    assign o_axis_value         = $signed(r_axis);
    assign o_sign_jump_warning  = r_warn_o;
    assign o_distance_saturated = r_sat_o;

endmodule
`default_nettype wire

// ===== tb/track_position_distance_accumulator_tb.sv =====
`default_nettype none
module track_position_distance_accumulator_tb;
    import tpda_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC_BITS   = DIST_FRAC_BITS_DEF;
    localparam int  ACC_WIDTH   = DIST_WIDTH_DEF;
    localparam int  CYCLE_LIMIT = 6_000_000;
    localparam int  HOLD_CYCLES = 1500;
    localparam longint LAT_SPAN = 5898240;
    localparam longint LON_LOW  = -11796480;
    localparam longint LON_HIGH = 23592960;

    typedef struct {
        logic signed [23:0] lat;
        logic signed [25:0] lon;
    } station_t;

    typedef struct {
        logic signed [40:0] axis_value;
        logic               warning;
        logic               saturated;
    } axis_beat_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic signed [23:0]    i_station_lat = '0;
    logic signed [25:0]    i_station_lon = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [40:0]    o_axis_value;
    logic                  o_sign_jump_warning;
    logic                  o_distance_saturated;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    track_position_distance_accumulator dut (.*);

    // Track model: configuration and running state
    logic [1:0] mdl_mode;
    logic       mdl_wrap, mdl_km, mdl_start_given;
    longint     mdl_prev_lat, mdl_prev_lon;
    logic       mdl_have_prev, mdl_warned;
    longint unsigned mdl_total;

    station_t   station_q[$];
    axis_beat_t axis_expect_q[$];

    int  fail_count = 0;
    int  beats_per_mode[4] = '{0, 0, 0, 0};
    int  warnings_seen = 0;
    longint cycle_count = 0;
    logic hold_req = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned lon_gap(longint a, longint b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic logic opposite_signs(longint a, longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // cosine of the mean latitude, Q30, from the sum of two latitudes
    function automatic longint unsigned mean_lat_cos(longint lat_sum);
        longint unsigned a, x, x2, p, t;
        longint unsigned divs[6] = '{132, 90, 56, 30, 12, 2};
        a = (lat_sum < 0) ? longint'(-lat_sum) : longint'(lat_sum);
        if (a > DEG180)
            a = DEG360 - a;
        x  = (a * RAD_PER_UNIT) >> 20;
        x2 = (x * x) >> 30;
        p  = 64'd1 << 30;
        for (int k = 0; k < 6; k++) begin
            t = ((x2 * p) >> 30) / divs[k];
            p = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
        end
        return p;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Work out the beat that one accepted station causes, and advance the track
    task automatic predict_station(input station_t s);
        longint lat, lon, pl;
        longint unsigned c, dx, dy, r, f, step, maxd;
        axis_beat_t e;
        lat  = s.lat;
        lon  = s.lon;
        maxd = (64'd1 << ACC_WIDTH) - 1;
        e.warning   = 1'b0;
        e.saturated = 1'b0;
        if (mdl_wrap && lon < 0)
            lon += DEG360;
        case (mdl_mode)
            MODE_LAT: e.axis_value = lat[40:0];
            MODE_LON: e.axis_value = lon[40:0];
            MODE_DIST: begin
                if (mdl_have_prev) begin
                    pl = mdl_prev_lon;
                    // dateline: pull the previous longitude onto this side
                    if (opposite_signs(lon, pl) && lon_gap(lon, pl) > DEG180)
                        pl = (lon < 0) ? pl - DEG360 : pl + DEG360;
                    c    = mean_lat_cos(lat + mdl_prev_lat);
                    dx   = (lon_gap(lon, pl) * c) >> 26;
                    dy   = lon_gap(lat, mdl_prev_lat) << 4;
                    r    = floor_sqrt(dx * dx + dy * dy);
                    f    = mdl_km ? KM_PER_DEG : NM_PER_DEG;
                    step = (r * f) >> (44 - FRAC_BITS);
                    if (step >= maxd - mdl_total)
                        mdl_total = maxd;
                    else
                        mdl_total += step;
                    if (opposite_signs(lon, pl) && lon_gap(lon, pl) > DEG179 && !mdl_warned) begin
                        mdl_warned = 1'b1;
                        e.warning  = 1'b1;
                    end
                end
                mdl_prev_lat  = lat;
                mdl_prev_lon  = lon;
                mdl_have_prev = 1'b1;
                e.axis_value  = mdl_total[40:0];
                e.saturated   = (mdl_total == maxd);
            end
            default: e.axis_value = '1;
        endcase
        axis_expect_q.push_back(e);
    endtask

    // Driver: bursts of random length, random gaps; hold the beat while stalled
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_station('{lat: i_station_lat, lon: i_station_lon});
            if (i_in_valid && o_in_stall) begin
                // hold the offered beat
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (station_q.size() > 0) begin
                station_t s;
                s = station_q.pop_front();
                i_in_valid    <= 1'b1;
                i_station_lat <= s.lat;
                i_station_lon <= s.lon;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall on a pattern of its own, check each beat against the oldest expectation
    int  stall_style = 0;
    int  style_left = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (axis_expect_q.size() == 0) begin
                $error("beat with nothing expected: axis_value %0d", o_axis_value);
                fail_count++;
            end else begin
                axis_beat_t e;
                e = axis_expect_q.pop_front();
                beats_per_mode[mdl_mode]++;
                if (o_sign_jump_warning)
                    warnings_seen++;
                if (o_axis_value !== e.axis_value) begin
                    $error("axis_value expected %0d got %0d", e.axis_value, o_axis_value);
                    fail_count++;
                end
                if (o_sign_jump_warning !== e.warning) begin
                    $error("sign_jump_warning expected %0b got %0b",
                           e.warning, o_sign_jump_warning);
                    fail_count++;
                end
                if (o_distance_saturated !== e.saturated) begin
                    $error("distance_saturated expected %0b got %0b",
                           e.saturated, o_distance_saturated);
                    fail_count++;
                end
            end
        end
        if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= (hold_left > 1);
        end else begin
            if (style_left == 0) begin
                stall_style <= $urandom_range(0, 3);
                style_left  <= $urandom_range(64, 256);
            end else begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 4) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Write one register and mirror it in the model; the block is idle here
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_AXIS_MODE:   mdl_mode = value[1:0];
            CFG_WRAP_LON:    mdl_wrap = value[0];
            CFG_UNITS_KM:    mdl_km = value[0];
            CFG_START_GIVEN: begin
                mdl_start_given = value[0];
                mdl_have_prev   = value[0];
            end
            CFG_START_LAT:   mdl_prev_lat = longint'(signed'(value[23:0]));
            CFG_START_LON:   mdl_prev_lon = longint'(signed'(value[25:0]));
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic wrap, input logic km,
                             input logic sg, input longint slat, input longint slon);
        write_reg(CFG_AXIS_MODE, mode);
        write_reg(CFG_WRAP_LON, wrap);
        write_reg(CFG_UNITS_KM, km);
        write_reg(CFG_START_GIVEN, sg);
        write_reg(CFG_START_LAT, slat);
        write_reg(CFG_START_LON, slon);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (station_q.size() == 0 && !i_in_valid && axis_expect_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_station(input longint lat, input longint lon);
        station_q.push_back('{lat: lat[23:0], lon: lon[25:0]});
    endtask

    // Random tracks: mostly a well-formed walk, some far jumps, some full-width noise
    task automatic push_track(input int count);
        longint lat, lon;
        lat = longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
        lon = longint'($urandom_range(0, LON_HIGH - LON_LOW)) + LON_LOW;
        for (int n = 0; n < count; n++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                lat += longint'($urandom_range(0, 400000)) - 200000;
                lon += longint'($urandom_range(0, 800000)) - 400000;
                if (lat > LAT_SPAN) lat = LAT_SPAN;
                if (lat < -LAT_SPAN) lat = -LAT_SPAN;
                // hop across the dateline now and then
                if ($urandom_range(0, 15) == 0)
                    lon = (lon >= 0) ? -DEG180 + longint'($urandom_range(0, 300000))
                                     : DEG180 - longint'($urandom_range(0, 300000));
                if (lon > LON_HIGH) lon = LON_HIGH;
                if (lon < LON_LOW) lon = LON_LOW;
                push_station(lat, lon);
            end else if (pick < 88) begin
                lat = longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
                lon = longint'($urandom_range(0, LON_HIGH - LON_LOW)) + LON_LOW;
                push_station(lat, lon);
            end else begin
                push_station(longint'(signed'(24'($urandom))),
                             longint'(signed'(26'($urandom))));
            end
        end
    endtask

    initial begin
        mdl_mode = MODE_DIST;
        mdl_wrap = 1'b0;
        mdl_km = 1'b0;
        mdl_start_given = 1'b0;
        mdl_prev_lat = 0;
        mdl_prev_lon = 0;
        mdl_have_prev = 1'b0;
        mdl_warned = 1'b0;
        mdl_total = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first station adds nothing, then poles, extremes, dateline
        push_station(0, 0);
        push_station(LAT_SPAN, DEG180);
        push_station(-LAT_SPAN, -DEG180);
        push_station(0, 5865472);
        push_station(0, -5900000);          // just under 180 apart: warning raised
        push_station(0, 11730000);
        push_station(100, -11730000);       // dateline crossing, warning already spent
        push_station(8388607, 33554431);    // out of range, top of both fields
        push_station(-8388608, -33554432);
        drain();

        // Longitude mode with wrap, latitude mode, undefined mode
        configure(MODE_LON, 1'b1, 1'b0, 1'b0, 0, 0);
        push_station(0, -1);
        push_station(0, LON_LOW);
        push_station(0, -33554432);
        push_station(0, LON_HIGH);
        drain();
        configure(MODE_LAT, 1'b0, 1'b0, 1'b0, 0, 0);
        push_station(LAT_SPAN, -1);
        push_station(-8388608, 0);
        push_station(8388607, 0);
        drain();
        configure(2'd3, 1'b0, 1'b0, 1'b0, 0, 0);
        push_station(1, 1);
        push_station(-1, -1);
        drain();

        // Distance in km, then in nautical miles, from given start positions at the extremes
        configure(MODE_DIST, 1'b1, 1'b1, 1'b1, -LAT_SPAN, LON_HIGH);
        push_station(LAT_SPAN, LON_LOW);
        push_station(0, -2000000);
        drain();
        configure(MODE_DIST, 1'b0, 1'b0, 1'b1, LAT_SPAN, LON_LOW);
        push_station(-LAT_SPAN, 0);
        drain();

        // Long receiver hold-off with cheap beats so the block backs up
        configure(MODE_LAT, 1'b0, 1'b0, 1'b0, 0, 0);
        hold_req <= 1'b1;
        push_track(60);
        drain();

        // Random phases, each with a fresh setting of every register
        for (int ph = 0; ph < 10; ph++) begin
            logic [1:0] mode;
            longint slat, slon;
            mode = ($urandom_range(0, 9) < 6) ? MODE_DIST : 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: begin slat = -LAT_SPAN; slon = LON_LOW; end
                1: begin slat = LAT_SPAN; slon = LON_HIGH; end
                default: begin
                    slat = longint'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN;
                    slon = longint'($urandom_range(0, LON_HIGH - LON_LOW)) + LON_LOW;
                end
            endcase
            configure(mode, $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1), slat, slon);
            push_track(115);
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Checked %0d latitude, %0d longitude, %0d distance and %0d undefined-mode beats",
                 beats_per_mode[0], beats_per_mode[1], beats_per_mode[2], beats_per_mode[3]);
        $display("Sign jump warnings seen: %0d, final track distance %0d", warnings_seen,
                 mdl_total);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
